@@ sv/h264nal_pkg.sv @@
// ----------------------------------------------------------------------------
// h264nal_pkg
// Types, codes and the NAL header decode shared by the inspector modules.
// ----------------------------------------------------------------------------
package h264nal_pkg;

    localparam logic [4:0] NAL_TYPE_MASK_W = 5'h1F;
    localparam logic [4:0] NAL_TYPE_IDR    = 5'd5;
    localparam logic [4:0] NAL_TYPE_SPS    = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS    = 5'd8;

    localparam int ANNEXB_MIN_ZEROS = 2;

    typedef struct packed {
        logic pps;
        logic sps;
        logic idr;
    } t_nal_flags;

    typedef enum logic [1:0] {
        FMT_NONE   = 2'd0,
        FMT_ANNEXB = 2'd1,
        FMT_LEN4   = 2'd2,
        FMT_LEN2   = 2'd3
    } t_format;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_SEEN = 2'd1,
        ST_FAIL = 2'd2
    } t_len_status;

    typedef struct packed {
        logic       ok;
        t_nal_flags flags;
    } t_parse_result;

    function automatic t_nal_flags nal_type_flags(input logic [7:0] hdr);
        t_nal_flags f;
        f = '0;
        unique case (hdr[4:0] & NAL_TYPE_MASK_W)
            NAL_TYPE_IDR: f.idr = 1'b1;
            NAL_TYPE_SPS: f.sps = 1'b1;
            NAL_TYPE_PPS: f.pps = 1'b1;
            default:      f = '0;
        endcase
        return f;
    endfunction

endpackage

@@ sv/h264_access_unit_nal_inspector_core.sv @@
// ----------------------------------------------------------------------------
// h264_access_unit_nal_inspector_core
// Scans one access unit a byte per transaction with Annex B, 4-byte and
// 2-byte length parsers side by side, and reports the NAL types found.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------
//   in      | sink      | i_in_valid / o_in_stall    | data byte, last flag
//   out     | source    | o_out_valid / i_out_stall  | idr, sps, pps, format
//
// One byte per cycle unless input is stalled; each byte passes the input
// register, then all three parsers and the result select update together.
// A final byte's result is registered as it leaves the input register.
// Reset clears all parser state; the next byte starts a new access unit.
// Only a final byte waiting on a stalled, full result register stalls input.
// ----------------------------------------------------------------------------
module h264_access_unit_nal_inspector_core
    import h264nal_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_has_idr_slice,
    output logic       o_has_sps,
    output logic       o_has_pps,
    output logic [1:0] o_format_found
);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_last;
    logic          r_out_valid;
    t_nal_flags    r_out_flags, n_out_flags;
    t_format       r_out_fmt, n_out_fmt;

    logic          out_free;
    logic          step;
    logic          in_ready;
    logic          emit;
    t_parse_result annexb_res;
    t_parse_result len4_res;
    t_parse_result len2_res;

    assign out_free = !r_out_valid || !i_out_stall;
    assign step     = r_in_valid && (!r_in_last || out_free);
    assign in_ready = !r_in_valid || step;
    assign emit     = step && r_in_last;

    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    h264nal_annexb u_annexb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_last   (r_in_last),
        .i_byte   (r_in_byte),
        .o_result (annexb_res)
    );

    h264nal_len_parser #(
        .PREFIX_BYTES (4)
    ) u_len4 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_last   (r_in_last),
        .i_byte   (r_in_byte),
        .o_result (len4_res)
    );

    h264nal_len_parser #(
        .PREFIX_BYTES (2)
    ) u_len2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_last   (r_in_last),
        .i_byte   (r_in_byte),
        .o_result (len2_res)
    );

    always_comb begin
        n_out_flags = '0;
        n_out_fmt   = FMT_NONE;
        if (annexb_res.ok) begin
            n_out_flags = annexb_res.flags;
            n_out_fmt   = FMT_ANNEXB;
        end else if (len4_res.ok) begin
            n_out_flags = len4_res.flags;
            n_out_fmt   = FMT_LEN4;
        end else if (len2_res.ok) begin
            n_out_flags = len2_res.flags;
            n_out_fmt   = FMT_LEN2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_flags <= n_out_flags;
            r_out_fmt   <= n_out_fmt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_has_idr_slice = r_out_flags.idr;
    assign o_has_sps       = r_out_flags.sps;
    assign o_has_pps       = r_out_flags.pps;
    assign o_format_found  = r_out_fmt;

`ifndef NO_ASSERTIONS
    a_no_flags_without_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_format_found == FMT_NONE)
            |-> (!o_has_idr_slice && !o_has_sps && !o_has_pps))
        else $error("flags set with no format found");

    a_stall_only_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_last && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked final byte");

    a_emit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_out_valid)
        else $error("final byte produced no result");
`endif

endmodule

@@ sv/h264nal_annexb.sv @@
// ----------------------------------------------------------------------------
// h264nal_annexb
// Annex B start code parser: tracks zero runs, start codes and the header
// byte of each unit, and reports its flags as of the current byte.
// ----------------------------------------------------------------------------
module h264nal_annexb
    import h264nal_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic          i_last,
    input  logic [7:0]    i_byte,
    output t_parse_result o_result
);

    logic [1:0] r_zero_run, n_zero_run;
    logic       r_started, n_started;
    logic       r_awaiting, n_awaiting;
    t_nal_flags r_flags, n_flags;

    always_comb begin
        n_zero_run = r_zero_run;
        n_started  = r_started;
        n_awaiting = r_awaiting;
        n_flags    = r_flags;
        if (i_byte == 8'h01 && r_zero_run >= 2'(ANNEXB_MIN_ZEROS)) begin
            n_started  = 1'b1;
            n_awaiting = 1'b1;
            n_zero_run = '0;
        end else if (i_byte == 8'h00) begin
            if (r_zero_run < 2'(ANNEXB_MIN_ZEROS)) begin
                n_zero_run = r_zero_run + 2'd1;
            end
        end else begin
            n_zero_run = '0;
            if (r_awaiting) begin
                n_flags    = r_flags | nal_type_flags(i_byte);
                n_awaiting = 1'b0;
            end
        end
    end

    assign o_result.ok    = n_started;
    assign o_result.flags = n_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= '0;
            r_started  <= 1'b0;
            r_awaiting <= 1'b0;
            r_flags    <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_zero_run <= '0;
                r_started  <= 1'b0;
                r_awaiting <= 1'b0;
                r_flags    <= '0;
            end else begin
                r_zero_run <= n_zero_run;
                r_started  <= n_started;
                r_awaiting <= n_awaiting;
                r_flags    <= n_flags;
            end
        end
    end

endmodule

@@ sv/h264nal_len_parser.sv @@
// ----------------------------------------------------------------------------
// h264nal_len_parser
// Length-prefixed NAL parser with big-endian prefixes of PREFIX_BYTES bytes.
// Fails on a zero length; reports success only at a clean unit boundary.
// ----------------------------------------------------------------------------
module h264nal_len_parser
    import h264nal_pkg::*;
#(
    parameter int PREFIX_BYTES = 4
)(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic          i_last,
    input  logic [7:0]    i_byte,
    output t_parse_result o_result
);

    localparam int LEN_W = 8 * PREFIX_BYTES;
    localparam int CNT_W = $clog2(PREFIX_BYTES + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_remaining, n_remaining;
    logic             r_awaiting, n_awaiting;
    t_len_status      r_status, n_status;
    t_nal_flags       r_flags, n_flags;

    logic [LEN_W-1:0] shifted;
    logic [CNT_W-1:0] count_inc;

    assign shifted   = {r_remaining[LEN_W-9:0], i_byte};
    assign count_inc = r_count + CNT_W'(1);

    always_comb begin
        n_count     = r_count;
        n_remaining = r_remaining;
        n_awaiting  = r_awaiting;
        n_status    = r_status;
        n_flags     = r_flags;
        if (r_status != ST_FAIL) begin
            if (r_count != '0 || r_remaining == '0) begin
                n_remaining = shifted;
                if (count_inc >= CNT_W'(PREFIX_BYTES)) begin
                    n_count = '0;
                    if (shifted == '0) begin
                        n_status = ST_FAIL;
                    end else begin
                        n_status   = ST_SEEN;
                        n_awaiting = 1'b1;
                    end
                end else begin
                    n_count = count_inc;
                end
            end else begin
                if (r_awaiting) begin
                    n_flags    = r_flags | nal_type_flags(i_byte);
                    n_awaiting = 1'b0;
                end
                n_remaining = r_remaining - LEN_W'(1);
            end
        end
    end

    assign o_result.ok    = (n_status == ST_SEEN) && (n_count == '0) && (n_remaining == '0);
    assign o_result.flags = n_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_remaining <= '0;
            r_awaiting  <= 1'b0;
            r_status    <= ST_NONE;
            r_flags     <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_count     <= '0;
                r_remaining <= '0;
                r_awaiting  <= 1'b0;
                r_status    <= ST_NONE;
                r_flags     <= '0;
            end else begin
                r_count     <= n_count;
                r_remaining <= n_remaining;
                r_awaiting  <= n_awaiting;
                r_status    <= n_status;
                r_flags     <= n_flags;
            end
        end
    end

endmodule

@@ tb/tb_h264_access_unit_nal_inspector_core.sv @@
// ----------------------------------------------------------------------------
// tb_h264_access_unit_nal_inspector_core
// Streams access units byte by byte into the NAL inspector: a short table of
// hand-built units, then random Annex B, 4-byte and 2-byte length-prefixed,
// broken and noise units. A local scanner predicts the flags and format of
// each unit the table leaves open, and every result transaction is checked in order.
// Both sides idle at random; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_h264_access_unit_nal_inspector_core;
    timeunit 1ns;
    timeprecision 1ps;

    import h264nal_pkg::*;

    typedef struct packed {
        logic    idr;
        logic    sps;
        logic    pps;
        t_format fmt;
    } t_au_result;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_au_result res;
    } t_dir_row;

    typedef struct packed {
        logic [2:0]  count;
        logic [31:0] remain;
        logic        wait_hdr;
        t_len_status status;
        t_nal_flags  flags;
    } t_len_scan;

    localparam logic [7:0] START_CODE_END = 8'h01;
    localparam int         RANDOM_BYTES   = 1600;
    localparam int         HOLD_CYCLES    = 200;
    localparam int         IDLE_LIMIT     = 2000;
    localparam int         DRAIN_CYCLES   = 10;

    localparam t_au_result NO_RES = '{1'b0, 1'b0, 1'b0, FMT_NONE};

    localparam t_dir_row DIR_TAB [26] = '{
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h65, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, FMT_ANNEXB}},
        '{8'hFF, 1'b1, 1'b1, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h67, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, FMT_LEN2}},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h02, 1'b0, 1'b0, NO_RES},
        '{8'h68, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h02, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h25, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h27, 1'b1, 1'b0, NO_RES}
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_has_idr_slice;
    logic       o_has_sps;
    logic       o_has_pps;
    logic [1:0] o_format_found;

    logic [1:0] sc_zero_run;
    logic       sc_started;
    logic       sc_wait_hdr;
    t_nal_flags sc_flags;
    t_len_scan  scan4;
    t_len_scan  scan2;

    t_au_result expected_results [$];
    logic [7:0] au_bytes [$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int bytes_accepted = 0;
    int tx_gap         = 0;
    bit tx_quiet       = 1'b0;
    bit rx_quiet       = 1'b0;
    bit hold_req       = 1'b0;

    h264_access_unit_nal_inspector_core i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_nal_flags header_flags(input logic [7:0] hdr);
        t_nal_flags f;
        f = '0;
        case (hdr[4:0])
            NAL_TYPE_IDR: f.idr = 1'b1;
            NAL_TYPE_SPS: f.sps = 1'b1;
            NAL_TYPE_PPS: f.pps = 1'b1;
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic t_len_scan len_scan_next(input t_len_scan s, input logic [7:0] b,
                                                input int size, input logic [31:0] mask);
        t_len_scan n;
        n = s;
        if (n.status != ST_FAIL) begin
            if (n.count != 3'd0 || n.remain == 32'd0) begin
                n.remain = ((n.remain << 8) | {24'd0, b}) & mask;
                n.count  = n.count + 3'd1;
                if (int'(n.count) >= size) begin
                    n.count = 3'd0;
                    if (n.remain == 32'd0) begin
                        n.status = ST_FAIL;
                    end else begin
                        n.status   = ST_SEEN;
                        n.wait_hdr = 1'b1;
                    end
                end
            end else begin
                if (n.wait_hdr) begin
                    n.flags    = n.flags | header_flags(b);
                    n.wait_hdr = 1'b0;
                end
                n.remain = (n.remain - 32'd1) & mask;
            end
        end
        return n;
    endfunction

    function automatic logic len_done(input t_len_scan s);
        return s.status == ST_SEEN && s.count == 3'd0 && s.remain == 32'd0;
    endfunction

    function automatic void scan_reset();
        sc_zero_run = 2'd0;
        sc_started  = 1'b0;
        sc_wait_hdr = 1'b0;
        sc_flags    = '0;
        scan4       = '0;
        scan2       = '0;
    endfunction

    function automatic logic predict_byte(input logic [7:0] b, input logic l,
                                          output t_au_result r);
        t_nal_flags f;
        r = NO_RES;
        f = '0;
        if (b == START_CODE_END && sc_zero_run >= 2'(ANNEXB_MIN_ZEROS)) begin
            sc_started  = 1'b1;
            sc_wait_hdr = 1'b1;
            sc_zero_run = 2'd0;
        end else if (b == 8'h00) begin
            if (sc_zero_run < 2'(ANNEXB_MIN_ZEROS))
                sc_zero_run = sc_zero_run + 2'd1;
        end else begin
            sc_zero_run = 2'd0;
            if (sc_wait_hdr) begin
                sc_flags    = sc_flags | header_flags(b);
                sc_wait_hdr = 1'b0;
            end
        end
        scan4 = len_scan_next(scan4, b, 4, 32'hFFFF_FFFF);
        scan2 = len_scan_next(scan2, b, 2, 32'h0000_FFFF);
        if (!l)
            return 1'b0;
        if (sc_started) begin
            f     = sc_flags;
            r.fmt = FMT_ANNEXB;
        end else if (len_done(scan4)) begin
            f     = scan4.flags;
            r.fmt = FMT_LEN4;
        end else if (len_done(scan2)) begin
            f     = scan2.flags;
            r.fmt = FMT_LEN2;
        end
        r.idr = f.idr;
        r.sps = f.sps;
        r.pps = f.pps;
        scan_reset();
        return 1'b1;
    endfunction

    function automatic logic [7:0] random_header();
        logic [7:0] h;
        h = 8'($urandom);
        case ($urandom_range(0, 3))
            0: h[4:0] = NAL_TYPE_IDR;
            1: h[4:0] = NAL_TYPE_SPS;
            2: h[4:0] = NAL_TYPE_PPS;
            default: h = h;
        endcase
        return h;
    endfunction

    function automatic logic [7:0] noise_byte();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    task automatic build_au();
        int kind;
        int size;
        int units;
        int len;
        au_bytes.delete();
        kind  = $urandom_range(0, 7);
        size  = (kind == 6) ? 2 * $urandom_range(1, 2) : (kind < 4) ? 4 : 2;
        units = $urandom_range(1, 4);
        for (int u = 0; u < units; u++) begin
            if (kind < 2) begin
                if ($urandom_range(0, 1) == 1)
                    au_bytes.push_back(8'h00);
                au_bytes.push_back(8'h00);
                au_bytes.push_back(8'h00);
                au_bytes.push_back(START_CODE_END);
                if ($urandom_range(0, 7) != 0)
                    au_bytes.push_back(random_header());
                repeat ($urandom_range(0, 8)) au_bytes.push_back(noise_byte());
            end else if (kind < 7) begin
                len = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 300)
                                                   : $urandom_range(1, 12);
                if (size == 4) begin
                    au_bytes.push_back(8'h00);
                    au_bytes.push_back(8'h00);
                end
                au_bytes.push_back(8'(len >> 8));
                au_bytes.push_back(8'(len));
                au_bytes.push_back(random_header());
                repeat (len - 1) au_bytes.push_back(noise_byte());
            end else begin
                repeat ($urandom_range(1, 4)) au_bytes.push_back(noise_byte());
            end
        end
        if (kind == 6) begin
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 3)) void'(au_bytes.pop_back());
            end else begin
                repeat (size) au_bytes.push_back(8'h00);
                au_bytes.push_back(random_header());
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                             input t_au_result typed_res);
        t_au_result r;
        repeat (tx_gap) @(posedge i_clk);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_accepted++;
        if (predict_byte(b, l, r))
            expected_results.push_back(typed ? typed_res : r);
        if ($urandom_range(0, 39) == 0)
            tx_quiet = !tx_quiet;
        tx_gap = tx_quiet ? 0 : $urandom_range(0, 10);
        if (tx_gap > 0)
            i_in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        if (tx_gap == 0)
            i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input t_au_result want,
                                   input t_au_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: %s: expected idr=%b sps=%b pps=%b fmt=%0d,",
                      " got idr=%b sps=%b pps=%b fmt=%0d"},
                     $realtime, what, want.idr, want.sps, want.pps, want.fmt,
                     got.idr, got.sps, got.pps, got.fmt);
    endtask

    always @(posedge i_clk) begin
        t_au_result want;
        t_au_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_has_idr_slice, o_has_sps, o_has_pps, t_format'(o_format_found)};
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", NO_RES, got);
            end else begin
                want = expected_results.pop_front();
                if (got.idr !== want.idr || got.sps !== want.sps
                    || got.pps !== want.pps || got.fmt !== want.fmt)
                    report_mismatch("field mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_h264_access_unit_nal_inspector_core: done, errors");
            $finish;
        end
    end

    initial begin : receiver
        int stall_cycles;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_quiet = !rx_quiet;
            stall_cycles = rx_quiet ? 0 : $urandom_range(0, 10);
            if (hold_req) begin
                stall_cycles = HOLD_CYCLES;
                hold_req     = 1'b0;
            end
            if (stall_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        scan_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIR_TAB[k])
            send_byte(DIR_TAB[k].data, DIR_TAB[k].last, DIR_TAB[k].typed, DIR_TAB[k].res);
        while (bytes_accepted < RANDOM_BYTES + $size(DIR_TAB)) begin
            build_au();
            if (!hold_done && bytes_accepted > 400) begin
                hold_req  = 1'b1;
                tx_quiet  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && bytes_accepted > 1000) begin
                drain_results();
                pause_done = 1'b1;
            end
            foreach (au_bytes[k])
                send_byte(au_bytes[k], k == au_bytes.size() - 1, 1'b0, NO_RES);
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_h264_access_unit_nal_inspector_core: done, clean");
        else
            $display("tb_h264_access_unit_nal_inspector_core: done, errors");
        $finish;
    end

endmodule
